>>> sv/scpw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the correction path walker.
package scpw_pkg;

  localparam int unsigned CoordW   = 5;
  localparam int unsigned DistW    = 5;
  localparam int unsigned QubitW   = 10;
  localparam int unsigned SideW    = 2;
  localparam int unsigned ResLimit = 32;
  localparam int unsigned CntW     = 5;

  localparam logic [DistW-1:0] DistReset = 5'd3;
  localparam logic [DistW-1:0] DistMin   = 5'd2;

  localparam logic FuncPair     = 1'b0;
  localparam logic FuncBoundary = 1'b1;
  localparam logic LatPlaquette = 1'b0;
  localparam logic LatStar      = 1'b1;

  typedef enum logic [SideW-1:0] {
    SideLeft   = 2'd0,
    SideRight  = 2'd1,
    SideBottom = 2'd2,
    SideTop    = 2'd3
  } side_e;

  typedef struct packed {
    logic              func;
    logic              lattice_kind;
    logic [CoordW-1:0] a_col;
    logic [CoordW-1:0] a_row;
    logic [CoordW-1:0] b_col;
    logic [CoordW-1:0] b_row;
  } req_t;

  typedef struct packed {
    logic [QubitW-1:0] qubit_index;
    logic              toggle_valid;
    logic [SideW-1:0]  side;
    logic              error;
    logic              last;
  } res_t;

endpackage

>>> sv/scpw_chan.sv
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload per transfer.
interface scpw_chan #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/scpw_mac.sv
`timescale 1ns / 1ps
// Shared multiply-add unit for qubit index and lattice offset arithmetic.
module scpw_mac #(
  parameter int unsigned AW = 5,
  parameter int unsigned OW = 11
) (
  input  logic [AW-1:0] a_i,
  input  logic [AW-1:0] b_i,
  input  logic [OW-1:0] c_i,
  output logic [OW-1:0] p_o
);
  logic [2*AW-1:0] prod;

  assign prod = a_i * b_i;
  assign p_o  = OW'(prod) + c_i;
endmodule

>>> sv/surface_code_correction_path_walker_top.sv
`timescale 1ns / 1ps
// Surface code correction path walker top level.
//
// req_i takes one route per transfer: a defect pair, or one defect matched
// to its nearest lattice boundary. res_o gives one result per step of the
// L-shaped route (columns first, then rows), each naming the data qubit
// to flip; the final result of a route carries last. An invalid defect gives
// a single error result; an empty route a single result with no toggle.
// cfg_we_i/cfg_wdata_i write the code distance (reset 3); the user is to
// write it only while idle, which the block itself does not enforce.
// A route is accepted, then a setup state on the shared multiply-add unit
// (vertical qubit offset d*(d-1), side choice, range check) precedes one
// result per cycle while the receiver takes them; up to 32 results per
// route. The multiply-add unit computes every qubit index, one per step.
// The result register lets the next route be accepted while the last
// result still waits. A stalled receiver holds the walker on its step.
// Reset returns the walker to idle, empties the result register and sets
// the distance to 3.
module surface_code_correction_path_walker_top #(
  parameter int unsigned MAX_DISTANCE = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [scpw_pkg::DistW-1:0] cfg_wdata_i,
  scpw_chan.sink                     req_i,
  scpw_chan.source                   res_o
);
  import scpw_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DISTANCE + 1);
  localparam int unsigned XW = (DW > CoordW) ? DW : CoordW;
  localparam int unsigned PW = XW + 2;
  localparam int unsigned MW = 2 * DW + 1;
  localparam logic signed [PW-1:0] One  = PW'(1);
  localparam logic signed [PW-1:0] Zero = '0;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSetup = 3'b010,
    StWalk  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [DistW-1:0]     dist_q;
  logic                 res_valid_q, res_valid_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  res_t                 res_q, res_d;
  logic                 load;

  logic [DW-1:0]        d_q;
  logic                 func_q, star_q, err_q;
  side_e                side_q;
  logic [MW-1:0]        vbase_q;
  logic signed [PW-1:0] pc_q, pr_q, tc_q, tr_q;

  logic [DW-1:0]        d_eff, dm1;
  logic signed [PW-1:0] d_s, f_s, lim_s;
  logic signed [PW-1:0] dl, dr, db, dt, best;
  logic                 err_d;
  side_e                side_d;
  logic                 accept, out_free;
  logic                 col_move, col_inc, row_inc, any_move, vert, more, last_step;
  logic signed [PW-1:0] x_s, y_s, npc, npr;
  logic [DW-1:0]        mac_a, mac_b;
  logic [MW-1:0]        mac_c, mac_p;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !res_valid_q || res_o.ready;
  assign req_i.ready = (state_q == StIdle);
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // Effective distance clamped to [2, MAX_DISTANCE].
  always_comb begin
    if (dist_q < DistMin) begin
      d_eff = DW'(DistMin);
    end else if (XW'(dist_q) > XW'(MAX_DISTANCE)) begin
      d_eff = DW'(MAX_DISTANCE);
    end else begin
      d_eff = DW'(dist_q);
    end
  end

  assign dm1   = d_q - DW'(1);
  assign d_s   = signed'(PW'(d_q));
  assign f_s   = d_s - One;
  assign lim_s = (star_q == LatStar) ? d_s : f_s;

  // Range check and nearest boundary.
  always_comb begin
    err_d = (pc_q >= lim_s) || (pr_q >= lim_s) ||
            ((func_q == FuncPair) && ((tc_q >= lim_s) || (tr_q >= lim_s)));
    dl = (star_q == LatStar) ? pc_q : pc_q + One;
    dr = f_s - pc_q;
    db = (star_q == LatStar) ? pr_q : pr_q + One;
    dt = f_s - pr_q;
    best   = dl;
    side_d = SideLeft;
    if (dr < best) begin
      best   = dr;
      side_d = SideRight;
    end
    if (db < best) begin
      best   = db;
      side_d = SideBottom;
    end
    if (dt < best) begin
      side_d = SideTop;
    end
  end

  // Step decode: qubit coordinates and next walker position.
  always_comb begin
    col_move = (pc_q != tc_q);
    col_inc  = (pc_q < tc_q);
    row_inc  = (pr_q < tr_q);
    any_move = col_move || (pr_q != tr_q);
    vert     = (star_q == LatStar) ? !col_move : col_move;
    x_s = pc_q;
    y_s = pr_q;
    npc = pc_q;
    npr = pr_q;
    if (col_move) begin
      npc = col_inc ? pc_q + One : pc_q - One;
      if (star_q == LatPlaquette && col_inc) begin
        x_s = pc_q + One;
      end else if (star_q == LatStar && !col_inc) begin
        x_s = pc_q - One;
      end
    end else begin
      npr = row_inc ? pr_q + One : pr_q - One;
      if (star_q == LatPlaquette && row_inc) begin
        y_s = pr_q + One;
      end else if (star_q == LatStar && !row_inc) begin
        y_s = pr_q - One;
      end
    end
    more      = (npc != tc_q) || (npr != tr_q);
    last_step = !more || (cnt_q == CntW'(ResLimit - 1));
  end

  always_comb begin
    if (state_q == StSetup) begin
      mac_a = d_q;
      mac_b = dm1;
      mac_c = '0;
    end else begin
      mac_a = y_s[DW-1:0];
      mac_b = vert ? d_q : dm1;
      mac_c = MW'(x_s[DW-1:0]) + (vert ? vbase_q : '0);
    end
  end

  scpw_mac #(
    .AW (DW),
    .OW (MW)
  ) u_mac (
    .a_i (mac_a),
    .b_i (mac_b),
    .c_i (mac_c),
    .p_o (mac_p)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    load        = 1'b0;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        cnt_d   = '0;
        state_d = StWalk;
      end
      StWalk: begin
        if (out_free) begin
          load = 1'b1;
          res_d.qubit_index  = '0;
          res_d.toggle_valid = 1'b0;
          res_d.side         = side_q;
          res_d.error        = 1'b0;
          res_d.last         = 1'b1;
          if (err_q) begin
            res_d.side  = SideLeft;
            res_d.error = 1'b1;
            state_d     = StIdle;
          end else if (!any_move) begin
            state_d = StIdle;
          end else begin
            res_d.qubit_index  = QubitW'(mac_p);
            res_d.toggle_valid = 1'b1;
            res_d.last         = last_step;
            cnt_d              = cnt_q + CntW'(1);
            if (last_step) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      dist_q      <= DistReset;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        dist_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
    if (accept) begin
      d_q    <= d_eff;
      func_q <= req_i.data.func;
      star_q <= req_i.data.lattice_kind;
      pc_q   <= signed'(PW'(req_i.data.a_col));
      pr_q   <= signed'(PW'(req_i.data.a_row));
      tc_q   <= signed'(PW'(req_i.data.b_col));
      tr_q   <= signed'(PW'(req_i.data.b_row));
    end else if (state_q == StSetup) begin
      vbase_q <= mac_p;
      err_q   <= err_d;
      if (func_q == FuncBoundary && !err_d) begin
        side_q <= side_d;
        case (side_d)
          SideLeft: begin
            tc_q <= (star_q == LatStar) ? Zero : -One;
            tr_q <= pr_q;
          end
          SideRight: begin
            tc_q <= f_s;
            tr_q <= pr_q;
          end
          SideBottom: begin
            tc_q <= pc_q;
            tr_q <= (star_q == LatStar) ? Zero : -One;
          end
          default: begin
            tc_q <= pc_q;
            tr_q <= f_s;
          end
        endcase
      end else begin
        side_q <= SideLeft;
      end
    end else if (load && !err_q && any_move) begin
      pc_q <= npc;
      pr_q <= npr;
    end
  end

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StSetup)
    else $error("accepted route did not enter setup");

  a_limit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res_d.toggle_valid && cnt_q == CntW'(ResLimit - 1)) |=> res_q.last)
    else $error("result limit reached without last");

  a_toggle_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.toggle_valid) |-> !res_q.error)
    else $error("toggle result flagged as error");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.error) |->
      (res_q.last && !res_q.toggle_valid && res_q.side == SideLeft))
    else $error("malformed error result");

endmodule
